>>> hw/rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg: shared types and microcode for the modular inverse block
// Holds the transaction payloads, the control word format and the program ROM.
// ----------------------------------------------------------------------------
package mie_pkg;

    localparam int IN_W   = 31;
    localparam int COEF_W = 32;
    localparam int CNT_W  = $clog2(IN_W);
    localparam int PC_W   = 3;

    typedef struct packed {
        logic [IN_W-1:0] value_in;
        logic [IN_W-1:0] modulus_in;
    } t_in_item;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic                     zero_modulus_error;
    } t_out_item;

    typedef logic [PC_W-1:0] t_pc;

    // Program addresses.
    localparam t_pc PC_IDLE     = 3'd0;
    localparam t_pc PC_CHECK    = 3'd1;
    localparam t_pc PC_DIV_INIT = 3'd2;
    localparam t_pc PC_DIV_STEP = 3'd3;
    localparam t_pc PC_TEST     = 3'd4;
    localparam t_pc PC_MUL      = 3'd5;
    localparam t_pc PC_UPDATE   = 3'd6;
    localparam t_pc PC_DONE     = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL,
        OP_UPDATE,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DEN_ZERO,
        C_CNT_NZ,
        C_REM_ZERO,
        C_OUT_BUSY
    } t_cond;

    // One control word: the datapath operation, and a jump taken when the
    // condition holds. Otherwise the program counter advances by one.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uop;

    // Status seen by the sequencer's jump conditions.
    typedef struct packed {
        logic in_valid;
        logic den_zero;
        logic cnt_nz;
        logic rem_zero;
        logic out_busy;
    } t_flags;

    function automatic t_uop uop_rom(input t_pc pc);
        t_uop uop;
        uop = '{op: OP_NOP, cond: C_NEVER, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:     uop = '{op: OP_LOAD,     cond: C_NO_INPUT, target: PC_IDLE};
            PC_CHECK:    uop = '{op: OP_NOP,      cond: C_DEN_ZERO, target: PC_DONE};
            PC_DIV_INIT: uop = '{op: OP_DIV_INIT, cond: C_NEVER,    target: PC_IDLE};
            PC_DIV_STEP: uop = '{op: OP_DIV_STEP, cond: C_CNT_NZ,   target: PC_DIV_STEP};
            PC_TEST:     uop = '{op: OP_NOP,      cond: C_REM_ZERO, target: PC_DONE};
            PC_MUL:      uop = '{op: OP_MUL,      cond: C_NEVER,    target: PC_IDLE};
            PC_UPDATE:   uop = '{op: OP_UPDATE,   cond: C_ALWAYS,   target: PC_DIV_INIT};
            PC_DONE:     uop = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: PC_DONE};
            default:     uop = '{op: OP_NOP,      cond: C_ALWAYS,   target: PC_IDLE};
        endcase
        return uop;
    endfunction

endpackage

>>> hw/rtl/mie_seq.sv
// ----------------------------------------------------------------------------
// mie_seq: microcode sequencer
// Program counter, control word ROM and conditional jump logic.
// ----------------------------------------------------------------------------
module mie_seq import mie_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uop   o_uop,
    output t_pc    o_pc
);

    t_pc  r_pc;
    t_pc  n_pc;
    t_uop w_uop;
    logic w_take;

    assign w_uop = uop_rom(r_pc);

    always_comb begin
        unique case (w_uop.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_INPUT: w_take = !i_flags.in_valid;
            C_DEN_ZERO: w_take = i_flags.den_zero;
            C_CNT_NZ:   w_take = i_flags.cnt_nz;
            C_REM_ZERO: w_take = i_flags.rem_zero;
            C_OUT_BUSY: w_take = i_flags.out_busy;
            default:    w_take = 1'b0;
        endcase
    end

    // The last step wraps to the idle step by plain increment.
    always_comb begin
        n_pc = w_take ? w_uop.target : t_pc'(r_pc + t_pc'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uop = w_uop;
    assign o_pc  = r_pc;

endmodule

>>> hw/rtl/modular_inverse_euclid_top.sv
// ----------------------------------------------------------------------------
// modular_inverse_euclid_top: modular inverse by extended Euclid
// Microcoded datapath that returns the Bezout coefficient of the value.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//
//  Each Euclid step runs one setup, a bit-serial restoring divider, a zero
//  test, one multiply and one update. The last division skips the multiply
//  and the update and goes to the emit step; a zero modulus skips the
//  division and goes from the check step straight to the emit step.
//  Reset is synchronous and active low; it returns the program to idle and
//  empties the output register. There is no clearing pass.
//  A new transaction is taken only at the idle step, which may run while a
//  finished result still waits in the output register for a stalled sink.
//
module modular_inverse_euclid_top import mie_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // Sequencer interface.
    t_uop   w_uop;
    t_pc    w_pc;
    t_flags w_flags;

    // Euclid state: remainder pair and the value's Bezout coefficients.
    logic [IN_W-1:0]          r_num, n_num;
    logic [IN_W-1:0]          r_den, n_den;
    logic signed [COEF_W-1:0] r_s_prev, n_s_prev;
    logic signed [COEF_W-1:0] r_s_cur, n_s_cur;
    logic                     r_err, n_err;

    // Divider state: partial remainder, quotient shifting in, bit counter.
    logic [IN_W-1:0]  r_rem, n_rem;
    logic [IN_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Registered product of quotient and current coefficient.
    logic signed [COEF_W:0] r_prod, n_prod;

    // Output register.
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic                       w_accept;
    logic                       w_slot_free;
    logic [IN_W:0]              w_trial;
    logic [IN_W:0]              w_diff;
    logic                       w_fits;
    logic signed [2*COEF_W-1:0] w_prod_full;
    logic signed [COEF_W:0]     w_s_next;

    // Only the idle step takes a transaction.
    assign o_in_stall  = (w_pc != PC_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    assign w_flags = '{
        in_valid: i_in_valid,
        den_zero: (r_den == '0),
        cnt_nz:   (r_cnt != '0),
        rem_zero: (r_rem == '0),
        out_busy: !w_slot_free
    };

    mie_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uop   (w_uop),
        .o_pc    (w_pc)
    );

    // One restoring division step: bring down the next dividend bit and
    // subtract the divisor when it fits.
    assign w_trial = {r_rem, r_quo[IN_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    // The quotient is non-negative, so it enters the product zero-extended.
    assign w_prod_full = $signed({{(COEF_W-IN_W){1'b0}}, r_quo}) * r_s_cur;

    // The new coefficient never exceeds the modulus in magnitude, so the
    // low bits of the wider difference are exact.
    assign w_s_next = {r_s_prev[COEF_W-1], r_s_prev} - r_prod;

    always_comb begin
        n_num       = r_num;
        n_den       = r_den;
        n_s_prev    = r_s_prev;
        n_s_cur     = r_s_cur;
        n_err       = r_err;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (w_uop.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                if (w_accept) begin
                    n_num    = i_in_data.value_in;
                    n_den    = i_in_data.modulus_in;
                    n_s_prev = COEF_W'(1);
                    n_s_cur  = '0;
                    n_err    = (i_in_data.modulus_in == '0);
                end
            end
            OP_DIV_INIT: begin
                n_rem = '0;
                n_quo = r_num;
                n_cnt = CNT_W'(IN_W - 1);
            end
            OP_DIV_STEP: begin
                n_rem = w_fits ? w_diff[IN_W-1:0] : w_trial[IN_W-1:0];
                n_quo = {r_quo[IN_W-2:0], w_fits};
                n_cnt = r_cnt - CNT_W'(1);
            end
            OP_MUL: begin
                n_prod = w_prod_full[COEF_W:0];
            end
            OP_UPDATE: begin
                n_num    = r_den;
                n_den    = r_rem;
                n_s_prev = r_s_cur;
                n_s_cur  = w_s_next[COEF_W-1:0];
            end
            OP_EMIT: begin
                // The sequencer holds here until the output register is free.
                if (w_slot_free) begin
                    n_out.coefficient        = r_s_cur;
                    n_out.zero_modulus_error = r_err;
                    n_out_valid              = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_num    <= n_num;
        r_den    <= n_den;
        r_s_prev <= n_s_prev;
        r_s_cur  <= n_s_cur;
        r_err    <= n_err;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_prod   <= n_prod;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A zero modulus must never report a nonzero coefficient.
    a_err_coef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uop.op == OP_EMIT && w_slot_free && r_err) |-> (r_s_cur == '0))
        else $error("zero modulus produced a nonzero coefficient");

    // After a full division the remainder is below the divisor.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pc == PC_TEST) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    // The divisor does not move while the divider iterates.
    a_den_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pc == PC_DIV_STEP) |-> $stable(r_den))
        else $error("divisor changed during division");

    // A result is written only into a free output slot.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result was overwritten or dropped");

endmodule
